// ===== sv/polyphonic_sine_voice_mixer_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sine voice mixer
// Immediate-consequence and next-cycle forms, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef POLYPHONIC_SINE_VOICE_MIXER_TOP_DEFINES_SVH
`define POLYPHONIC_SINE_VOICE_MIXER_TOP_DEFINES_SVH

// ante holds -> cons holds in the same cycle
`define PSVM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// ante holds -> cons holds in the next cycle
`define PSVM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== sv/psvm_pkg.sv =====
// ----------------------------------------------------------------------------
// psvm_pkg
// Shared types, widths, register codes and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package psvm_pkg;

	localparam int VOICES       = 8;
	localparam int SINE_ENTRIES = 1024;
	localparam int PHASE_BITS   = 24;

	localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int SE_BITS = $clog2(SINE_ENTRIES);
	localparam int QTR     = SINE_ENTRIES / 4;
	localparam int QIDX_W  = SE_BITS - 2;
	localparam int XSH     = 18 - SE_BITS;

	// field widths
	localparam int FUNC_W   = 2;
	localparam int STEP_W   = 24;
	localparam int LEN_W    = 24;
	localparam int LVL_W    = 15;
	localparam int AMP_W    = 16;
	localparam int RAMP_W   = 16;
	localparam int MAG_W    = 15;
	localparam int SAMPLE_W = 16;
	localparam int IN_DATA_W = ((STEP_W + LEN_W + LVL_W + 7) / 8) * 8;

	// datapath widths
	localparam int PROD_W  = MAG_W + AMP_W;
	localparam int WIDE_W  = PROD_W + RAMP_W;
	localparam int DIV_W   = WIDE_W + (WIDE_W % 2);
	localparam int ACC_W   = PROD_W + $clog2(VOICES + 2) + 1;
	localparam int SCALE_SH = 15;

	localparam logic [AMP_W-1:0]  VOL_MAX   = AMP_W'(32768);
	localparam logic [RAMP_W-1:0] DRONE_DIV = RAMP_W'(5);

	// configuration port
	localparam int CFG_REGS   = 6;
	localparam int CFG_ADDR_W = $clog2(CFG_REGS * 4);
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VOLUME,
		REG_MUTED,
		REG_ATTACK,
		REG_RELEASE,
		REG_DRONE_STEP,
		REG_DRONE_LEVEL
	} reg_idx_t;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK,
		FUNC_PLAY,
		FUNC_DRONE_START,
		FUNC_DRONE_STOP
	} func_t;

	typedef struct packed {
		logic [15:0] volume;
		logic        muted;
		logic [15:0] attack;
		logic [15:0] release_len;
		logic [23:0] drone_step;
		logic [14:0] drone_level;
	} cfg_t;

	localparam logic [15:0] VOLUME_RST      = 16'd32768;
	localparam logic [15:0] ATTACK_RST      = 16'd240;
	localparam logic [15:0] RELEASE_RST     = 16'd1440;
	localparam logic [23:0] DRONE_STEP_RST  = 24'd45718;
	localparam logic [14:0] DRONE_LEVEL_RST = 15'd2294;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [RAMP_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} sine_t;

	typedef logic [MAG_W-1:0] qrom_t [QTR];

	// odd polynomial over one quadrant, x in 0..65536 (Q16 quarter turn)
	function automatic logic [MAG_W-1:0] sine_poly(longint unsigned x);
		longint unsigned x2;
		longint unsigned t;
		longint unsigned y;
		longint unsigned v;
		x2 = (x * x) >> 16;
		t  = 64'd1337024 - ((x2 * 64'd78547) >> 16);
		t  = 64'd10837505 - ((x2 * t) >> 16);
		t  = 64'd26353589 - ((x2 * t) >> 16);
		y  = (x * t) >> 16;
		v  = (y * 64'd32767 + 64'd8388608) >> 24;
		return v[MAG_W-1:0];
	endfunction

	function automatic qrom_t sine_quarter();
		qrom_t tab;
		for (int i = 0; i < QTR; i++) begin
			tab[i] = sine_poly(longint'(i) << XSH);
		end
		return tab;
	endfunction

	localparam logic [MAG_W-1:0] SINE_PEAK = sine_poly(64'd65536);

endpackage

// ===== sv/polyphonic_sine_voice_mixer_top.sv =====
// ----------------------------------------------------------------------------
// polyphonic_sine_voice_mixer_top
// Sine voice mixer with drone: a sequencer walks the voices and drone
// partials through one sine table, one multiplier and one divider.
//
//   channel  dir  signals                         contents
//   s_*      in   s_tvalid s_tready s_tuser s_tdata  func / step, length, level
//   m_*      out  m_tvalid m_tready m_tdata          mixed sample Q1.15
//   apb      in   psel penable pwrite paddr pwdata   six config registers
//
// Play and drone start pass through a multiply state and a write-back state;
// drone stop acts in idle, and a muted tick goes straight to the finish state.
// A tick checks each voice, scales active voices by sine and gain, divides
// ramping voices by their ramp length, adds the drone, then rounds and saturates.
// s_tready is high only while the sequencer is idle; a finished sample waits
// in the output register, and a tick stalls at its end while it is full.
// Reset clears voices and drone; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "polyphonic_sine_voice_mixer_top_defines.svh"

module polyphonic_sine_voice_mixer_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [psvm_pkg::FUNC_W-1:0]            s_tuser,  // func
	// tone_step [23:0], tone_length [47:24], tone_level [62:48]
	input  logic [psvm_pkg::IN_DATA_W-1:0]         s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic signed [psvm_pkg::SAMPLE_W-1:0]   m_tdata,  // sample
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [psvm_pkg::CFG_ADDR_W-1:0]        paddr,
	input  logic [psvm_pkg::CFG_DATA_W-1:0]        pwdata,
	output logic [psvm_pkg::CFG_DATA_W-1:0]        prdata,
	output logic                                   pready
);
	import psvm_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE,
		S_PLAY,
		S_PLAYW,
		S_DSCALE,
		S_DSCALEW,
		S_VCHK,
		S_VSIN,
		S_VMUL,
		S_VDIVS,
		S_VDIV,
		S_DRN_FUND,
		S_DRN_MUL1,
		S_DRN_ADD1,
		S_DRN_MUL2,
		S_DRN_ADD2,
		S_DRN_PH3,
		S_DRN_MUL3,
		S_DRN_DIV3,
		S_DRN_ADD3,
		S_FIN
	} state_t;

	localparam logic signed [ACC_W-1:0] SAT_POS = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_NEG = -SAT_POS;

	cfg_t      cfg;
	sine_t     sine;
	div_req_t  div_req;
	logic      div_done;
	logic [DIV_W-1:0] div_quo;

	state_t                     state_q;
	logic [VIDX_W-1:0]          vidx_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic [WIDE_W-1:0]          prod_q;
	logic                       neg_q;
	logic [RAMP_W-1:0]          num_q;
	logic [RAMP_W-1:0]          den_q;
	logic                       envone_q;
	logic [STEP_W-1:0]          in_step_q;
	logic [LEN_W-1:0]           in_len_q;
	logic [LVL_W-1:0]           in_lvl_q;
	logic                       m_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	logic [VOICES-1:0]          voice_on_q;
	logic [PHASE_BITS-1:0]      voice_phase_q   [VOICES];
	logic [PHASE_BITS-1:0]      voice_step_q    [VOICES];
	logic [LEN_W-1:0]           voice_length_q  [VOICES];
	logic [LEN_W-1:0]           voice_elapsed_q [VOICES];
	logic [AMP_W-1:0]           voice_amp_q     [VOICES];
	logic                       drone_on_q;
	logic [PHASE_BITS-1:0]      drone_phase_q;
	logic [AMP_W-1:0]           drone_amp_q;

	logic [AMP_W-1:0]           vol;
	logic [PROD_W-1:0]          mul_a;
	logic [AMP_W-1:0]           mul_b;
	logic [WIDE_W-1:0]          mul_p;
	logic [PHASE_BITS-1:0]      sin_phase;
	logic [VIDX_W-1:0]          free_idx;
	logic [PHASE_BITS+1:0]      p3_full;
	logic [PHASE_BITS+2:0]      p6;
	logic [LEN_W-1:0]           cur_e;
	logic [LEN_W-1:0]           cur_rem;
	logic [LEN_W:0]             e_next;
	logic                       in_attack;
	logic                       in_release;
	logic signed [ACC_W-1:0]    acc_bias;
	logic signed [ACC_W-1:0]    acc_div;
	logic signed [SAMPLE_W-1:0] sat_sample;
	logic                       last_voice;

	psvm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	psvm_sine u_sine (
		.clk   (clk),
		.phase (sin_phase),
		.sine  (sine)
	);

	psvm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	function automatic logic signed [ACC_W-1:0] signed_term(logic [PROD_W-1:0] m, logic n);
		logic signed [ACC_W-1:0] v;
		v = ACC_W'(m);
		return n ? -v : v;
	endfunction

	assign vol = (cfg.volume > VOL_MAX) ? VOL_MAX : cfg.volume;

	// lowest free voice, voice 0 when all are busy
	always_comb begin
		free_idx = '0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (!voice_on_q[i]) free_idx = VIDX_W'(i);
		end
	end

	assign cur_e      = voice_elapsed_q[vidx_q];
	assign cur_rem    = voice_length_q[vidx_q] - cur_e;
	assign e_next     = {1'b0, cur_e} + 1'b1;
	assign in_attack  = cur_e < LEN_W'(cfg.attack);
	assign in_release = cur_rem < LEN_W'(cfg.release_len);
	assign last_voice = (vidx_q == VIDX_W'(VOICES - 1));

	assign p3_full = ({2'b0, drone_phase_q} + {1'b0, drone_phase_q, 1'b0});
	assign p6      = ({1'b0, drone_phase_q, 2'b0} + {2'b0, drone_phase_q, 1'b0});

	// shared multiplier
	always_comb begin
		case (state_q)
			S_VSIN: begin
				mul_a = PROD_W'(sine.mag);
				mul_b = voice_amp_q[vidx_q];
			end
			S_DRN_MUL1, S_DRN_MUL2, S_DRN_MUL3: begin
				mul_a = PROD_W'(sine.mag);
				mul_b = drone_amp_q;
			end
			S_VMUL: begin
				mul_a = prod_q[PROD_W-1:0];
				mul_b = num_q;
			end
			S_PLAY: begin
				mul_a = PROD_W'(in_lvl_q);
				mul_b = vol;
			end
			S_DSCALE: begin
				mul_a = PROD_W'(cfg.drone_level);
				mul_b = vol;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = WIDE_W'(mul_a) * WIDE_W'(mul_b);

	always_comb begin
		case (state_q)
			S_VCHK:     sin_phase = voice_phase_q[vidx_q];
			S_DRN_ADD1: sin_phase = p3_full[PHASE_BITS:1];
			S_DRN_PH3:  sin_phase = div_quo[PHASE_BITS-1:0];
			default:    sin_phase = drone_phase_q;
		endcase
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = DRONE_DIV;
		case (state_q)
			S_VDIVS: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(prod_q);
				div_req.divisor  = den_q;
			end
			S_DRN_ADD2: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(p6);
			end
			S_DRN_DIV3: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'({prod_q[PROD_W-1:0], 1'b0});
			end
			default: ;
		endcase
	end

	// divide by 32768 toward zero, then clip to +-32767
	always_comb begin
		acc_bias = acc_q + (acc_q[ACC_W-1] ? ACC_W'(32767) : ACC_W'(0));
		acc_div  = acc_bias >>> SCALE_SH;
		if (acc_div > SAT_POS) begin
			sat_sample = SAMPLE_W'(SAT_POS);
		end else if (acc_div < SAT_NEG) begin
			sat_sample = SAMPLE_W'(SAT_NEG);
		end else begin
			sat_sample = acc_div[SAMPLE_W-1:0];
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			vidx_q        <= '0;
			m_valid_q     <= 1'b0;
			voice_on_q    <= '0;
			drone_on_q    <= 1'b0;
			drone_phase_q <= '0;
			for (int i = 0; i < VOICES; i++) begin
				voice_phase_q[i] <= '0;
			end
		end else begin
			// S_FIN decides the output valid itself
			if (m_tready && (state_q != S_FIN)) m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						in_step_q <= s_tdata[STEP_W-1:0];
						in_len_q  <= s_tdata[STEP_W +: LEN_W];
						in_lvl_q  <= s_tdata[STEP_W+LEN_W +: LVL_W];
						case (func_t'(s_tuser))
							FUNC_TICK: begin
								acc_q   <= '0;
								vidx_q  <= '0;
								state_q <= cfg.muted ? S_FIN : S_VCHK;
							end
							FUNC_PLAY: begin
								if (!cfg.muted) state_q <= S_PLAY;
							end
							FUNC_DRONE_START: state_q <= S_DSCALE;
							FUNC_DRONE_STOP:  drone_on_q <= 1'b0;
							default: ;
						endcase
					end
				end
				S_PLAY: begin
					prod_q  <= mul_p;
					state_q <= S_PLAYW;
				end
				S_PLAYW: begin
					voice_step_q[free_idx]    <= PHASE_BITS'(in_step_q);
					voice_length_q[free_idx]  <= in_len_q;
					voice_amp_q[free_idx]     <= prod_q[SCALE_SH +: AMP_W];
					voice_elapsed_q[free_idx] <= '0;
					voice_on_q[free_idx]      <= 1'b1;
					state_q                   <= S_IDLE;
				end
				S_DSCALE: begin
					prod_q  <= mul_p;
					state_q <= S_DSCALEW;
				end
				S_DSCALEW: begin
					drone_amp_q <= prod_q[SCALE_SH +: AMP_W];
					drone_on_q  <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_VCHK: begin
					if (!voice_on_q[vidx_q]) begin
						if (last_voice) begin
							vidx_q  <= '0;
							state_q <= drone_on_q ? S_DRN_FUND : S_FIN;
						end else begin
							vidx_q <= vidx_q + 1'b1;
						end
					end else begin
						// release ramp wins over attack ramp
						if (in_release) begin
							num_q    <= cur_rem[RAMP_W-1:0];
							den_q    <= cfg.release_len;
							envone_q <= 1'b0;
						end else if (in_attack) begin
							num_q    <= cur_e[RAMP_W-1:0];
							den_q    <= cfg.attack;
							envone_q <= 1'b0;
						end else begin
							envone_q <= 1'b1;
						end
						voice_phase_q[vidx_q]   <= voice_phase_q[vidx_q] + voice_step_q[vidx_q];
						voice_elapsed_q[vidx_q] <= e_next[LEN_W-1:0];
						if (e_next >= {1'b0, voice_length_q[vidx_q]}) begin
							voice_on_q[vidx_q] <= 1'b0;
						end
						state_q <= S_VSIN;
					end
				end
				S_VSIN: begin
					prod_q  <= mul_p;
					neg_q   <= sine.neg;
					state_q <= S_VMUL;
				end
				S_VMUL: begin
					if (envone_q) begin
						acc_q <= acc_q + signed_term(prod_q[PROD_W-1:0], neg_q);
						if (last_voice) begin
							vidx_q  <= '0;
							state_q <= drone_on_q ? S_DRN_FUND : S_FIN;
						end else begin
							vidx_q  <= vidx_q + 1'b1;
							state_q <= S_VCHK;
						end
					end else begin
						prod_q  <= mul_p;
						state_q <= S_VDIVS;
					end
				end
				S_VDIVS: state_q <= S_VDIV;
				S_VDIV: begin
					if (div_done) begin
						acc_q <= acc_q + signed_term(div_quo[PROD_W-1:0], neg_q);
						if (last_voice) begin
							vidx_q  <= '0;
							state_q <= drone_on_q ? S_DRN_FUND : S_FIN;
						end else begin
							vidx_q  <= vidx_q + 1'b1;
							state_q <= S_VCHK;
						end
					end
				end
				S_DRN_FUND: state_q <= S_DRN_MUL1;
				S_DRN_MUL1: begin
					prod_q  <= mul_p;
					neg_q   <= sine.neg;
					state_q <= S_DRN_ADD1;
				end
				S_DRN_ADD1: begin
					acc_q   <= acc_q + signed_term(prod_q[PROD_W-1:0], neg_q);
					state_q <= S_DRN_MUL2;
				end
				S_DRN_MUL2: begin
					prod_q  <= mul_p;
					neg_q   <= sine.neg;
					state_q <= S_DRN_ADD2;
				end
				S_DRN_ADD2: begin
					// half-amplitude partial; the divider starts on 6p/5
					acc_q   <= acc_q + signed_term(prod_q[PROD_W:1], neg_q);
					state_q <= S_DRN_PH3;
				end
				S_DRN_PH3: begin
					if (div_done) state_q <= S_DRN_MUL3;
				end
				S_DRN_MUL3: begin
					prod_q  <= mul_p;
					neg_q   <= sine.neg;
					state_q <= S_DRN_DIV3;
				end
				S_DRN_DIV3: state_q <= S_DRN_ADD3;
				S_DRN_ADD3: begin
					if (div_done) begin
						acc_q         <= acc_q + signed_term(div_quo[PROD_W-1:0], neg_q);
						drone_phase_q <= drone_phase_q + PHASE_BITS'(cfg.drone_step);
						state_q       <= S_FIN;
					end
				end
				S_FIN: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						sample_q  <= sat_sample;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PSVM_ASSERT_IMP(a_div_done_wait, div_done, (state_q == S_VDIV) || (state_q == S_DRN_PH3) || (state_q == S_DRN_ADD3), "divider finished outside a wait state")
	`PSVM_ASSERT_IMP(a_muted_silent, (state_q == S_FIN) && cfg.muted, acc_q == '0, "muted tick carries a nonzero sum")
	`PSVM_ASSERT_IMP(a_sample_clip, m_tvalid, m_tdata != 16'h8000, "sample outside the clip range")
	`PSVM_ASSERT_NXT(a_fin_loads, (state_q == S_FIN) && (!m_valid_q || m_tready), m_tvalid && (state_q == S_IDLE), "finished sample not presented")

endmodule

// ===== sv/psvm_regs.sv =====
// ----------------------------------------------------------------------------
// psvm_regs
// Configuration register file behind a simple APB slave.
// ----------------------------------------------------------------------------
module psvm_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [psvm_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [psvm_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [psvm_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready,
	output psvm_pkg::cfg_t                      cfg
);
	import psvm_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volume      <= VOLUME_RST;
			cfg_q.muted       <= 1'b0;
			cfg_q.attack      <= ATTACK_RST;
			cfg_q.release_len <= RELEASE_RST;
			cfg_q.drone_step  <= DRONE_STEP_RST;
			cfg_q.drone_level <= DRONE_LEVEL_RST;
		end else if (wr_en) begin
			case (idx)
				REG_VOLUME:      cfg_q.volume      <= pwdata[15:0];
				REG_MUTED:       cfg_q.muted       <= pwdata[0];
				REG_ATTACK:      cfg_q.attack      <= pwdata[15:0];
				REG_RELEASE:     cfg_q.release_len <= pwdata[15:0];
				REG_DRONE_STEP:  cfg_q.drone_step  <= pwdata[23:0];
				REG_DRONE_LEVEL: cfg_q.drone_level <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_VOLUME:      prdata = CFG_DATA_W'(cfg_q.volume);
			REG_MUTED:       prdata = CFG_DATA_W'(cfg_q.muted);
			REG_ATTACK:      prdata = CFG_DATA_W'(cfg_q.attack);
			REG_RELEASE:     prdata = CFG_DATA_W'(cfg_q.release_len);
			REG_DRONE_STEP:  prdata = CFG_DATA_W'(cfg_q.drone_step);
			REG_DRONE_LEVEL: prdata = CFG_DATA_W'(cfg_q.drone_level);
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== sv/psvm_sine.sv =====
// ----------------------------------------------------------------------------
// psvm_sine
// Phase to sine lookup: quarter-wave table with registered read.
// Result is valid the cycle after the phase is presented.
// ----------------------------------------------------------------------------
module psvm_sine (
	input  logic                             clk,
	input  logic [psvm_pkg::PHASE_BITS-1:0]  phase,
	output psvm_pkg::sine_t                  sine
);
	import psvm_pkg::*;

	localparam qrom_t SINE_ROM = sine_quarter();

	logic [SE_BITS-1:0] k;
	logic [1:0]         quad;
	logic [QIDX_W-1:0]  j;
	logic [QIDX_W-1:0]  idx;
	logic               peak;

	logic [MAG_W-1:0]   rom_s1;
	logic               peak_s1;
	logic               neg_s1;

	assign k    = phase[PHASE_BITS-1 -: SE_BITS];
	assign quad = k[SE_BITS-1:SE_BITS-2];
	assign j    = k[QIDX_W-1:0];
	// falling quadrants mirror the table; their zero offset is the crest
	assign peak = quad[0] && (j == '0);
	assign idx  = quad[0] ? (~j + 1'b1) : j;

	always_ff @(posedge clk) begin
		rom_s1  <= SINE_ROM[idx];
		peak_s1 <= peak;
		neg_s1  <= quad[1];
	end

	assign sine.neg = neg_s1;
	assign sine.mag = peak_s1 ? SINE_PEAK : rom_s1;

endmodule

// ===== sv/psvm_div.sv =====
// ----------------------------------------------------------------------------
// psvm_div
// Unsigned restoring divider, two quotient bits per cycle.
// done pulses together with the last step's quotient; quotient holds until next start.
// ----------------------------------------------------------------------------
module psvm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  psvm_pkg::div_req_t            req,
	output logic                          done,
	output logic [psvm_pkg::DIV_W-1:0]    quotient
);
	import psvm_pkg::*;

	localparam int STEPS = DIV_W / 2;
	localparam int CNT_W = $clog2(STEPS);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [RAMP_W-1:0]  rem_q;
	logic [DIV_W-1:0]   quo_q;
	logic [RAMP_W-1:0]  den_q;

	logic [RAMP_W-1:0]  rem_nx;
	logic [DIV_W-1:0]   quo_nx;

	always_comb begin
		logic [RAMP_W:0] t;
		logic            ge;
		rem_nx = rem_q;
		quo_nx = quo_q;
		for (int b = 0; b < 2; b++) begin
			t      = {rem_nx, quo_nx[DIV_W-1]};
			ge     = (t >= {1'b0, den_q});
			quo_nx = {quo_nx[DIV_W-2:0], ge};
			rem_nx = ge ? RAMP_W'(t - {1'b0, den_q}) : t[RAMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= req.dividend;
				den_q  <= req.divisor;
			end else if (busy_q) begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
